FILE: hdl/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: hdl/ppfe_pkg.sv
package ppfe_pkg;

    // rounding modes
    typedef enum logic [2:0] {
        RND_NEAREST_EVEN = 3'd0,
        RND_TOWARD_ZERO  = 3'd1,
        RND_DOWN         = 3'd2,
        RND_UP           = 3'd3,
        RND_NEAREST_AWAY = 3'd4
    } round_mode_t;

    // configuration register map
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROUND_MODE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_FORMAT = 1'd1;

    // pipeline and datapath sizes
    localparam int PIPE_DEPTH = 8;
    localparam int CNT_W      = 4;
    localparam int ACC_W      = 60;
    localparam int MAN_W      = 59;
    localparam int LZ_W       = 7;
    localparam int EXP_W      = 10;

    // leading-zero count reported for a zero magnitude
    localparam logic [LZ_W-1:0] LZ_ZERO_SP = 7'd64;
    localparam logic [LZ_W-1:0] LZ_ZERO_HP = 7'd32;

    // alignment right shift with flush limit, then optional negation
    function automatic logic [ACC_W-1:0] align_term(input logic [ACC_W-1:0] v,
                                                     input logic [EXP_W-1:0] d,
                                                     input logic [EXP_W-1:0] lim,
                                                     input logic neg);
        logic [ACC_W-1:0] s;
        s = (d > lim) ? '0 : (v >> d);
        return neg ? (ACC_W'(0) - s) : s;
    endfunction

    // leading zeros of a nonzero magnitude, 64 for zero
    function automatic logic [LZ_W-1:0] lead_zeros(input logic [MAN_W-1:0] man);
        logic [LZ_W-1:0] lz;
        lz = LZ_ZERO_SP;
        for (int i = 0; i < MAN_W; i++) begin
            if (man[i]) lz = LZ_W'(MAN_W - 1 - i);
        end
        return lz;
    endfunction

endpackage

FILE: hdl/piecewise_poly_float_eval_core.sv
// datapath: from input request to result request, one register stage each in the stages below
// throughput: one request per cycle while the output is not stalled; the per-stage ready chain fills bubbles on stalls
// the widest stage is the 26x24 product feeding the linear term (stage 1)
// reset: synchronous active-low aresetn clears all valid bits, round_mode and half_format
// after reset s_ready is high, so the block takes requests at once; no memory to clear
module piecewise_poly_float_eval_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [ppfe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ppfe_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [31:0]                      s_x_bits,
    input  logic [38:0]                      s_coef_zero,
    input  logic [33:0]                      s_coef_one,
    input  logic [24:0]                      s_coef_two,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [31:0]                      m_result_bits
);

    localparam int D = ppfe_pkg::PIPE_DEPTH;

    // configuration registers
    logic [2:0] round_mode_reg;
    logic       half_format_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            round_mode_reg  <= 3'd0;
            half_format_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                ppfe_pkg::CFG_ROUND_MODE:  round_mode_reg  <= cfg_data;
                ppfe_pkg::CFG_HALF_FORMAT: half_format_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // stage handshake: a stage loads when empty or when the next one moves
    logic [D-1:0] vld_reg, vld_next;
    logic [D-1:0] hf_reg, hf_next;
    logic [D-1:0] rdy;

    always_comb begin
        rdy[D-1] = !vld_reg[D-1] || m_ready;
        for (int k = D - 2; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        vld_next[0] = rdy[0] ? s_valid : vld_reg[0];
        hf_next[0]  = rdy[0] ? half_format_reg : hf_reg[0];
        for (int k = 1; k < D; k++) begin
            vld_next[k] = rdy[k] ? vld_reg[k-1] : vld_reg[k];
            hf_next[k]  = rdy[k] ? hf_reg[k-1] : hf_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        hf_reg <= hf_next;
    end

    assign s_ready = rdy[0];
    assign m_valid = vld_reg[D-1];

    // stage 1: unpack, exponent sums, x*x and c1*x products
    logic [7:0]  ex;
    logic [22:0] fx;
    logic [7:0]  e0, e1, e2;
    logic        xden;
    logic [23:0] mxm;
    logic [25:0] m1;
    logic [9:0]  ee0, ee1, ee2, mx32;
    logic [4:0]  exh, e0h, e1h;
    logic [9:0]  fxh;
    logic        xdenh;
    logic [10:0] mxmh;
    logic [13:0] m1h;
    logic [5:0]  ee0h, ee1h, mxh;

    logic [47:0] sq_reg, sq_next;
    logic [49:0] p1_reg, p1_next;
    logic [16:0] m2_reg, m2_next;
    logic [30:0] m0_reg, m0_next;
    logic [9:0]  ee1_reg, ee1_next, ee2_reg, ee2_next, ee0_reg, ee0_next;
    logic [9:0]  mx_reg, mx_next;
    logic [24:0] p1h_reg, p1h_next;
    logic [15:0] m0h_reg, m0h_next;
    logic [5:0]  ee0h_reg, ee0h_next, ee1h_reg, ee1h_next, mxh_reg, mxh_next;
    logic        n0_reg, n0_next, n1_reg, n1_next, n2_reg, n2_next;

    always_comb begin
        ex   = s_x_bits[30:23];
        fx   = s_x_bits[22:0];
        e0   = s_coef_zero[37:30];
        e1   = s_coef_one[32:25];
        e2   = s_coef_two[23:16];
        xden = (ex == 8'd0) && (fx != 23'd0);
        mxm  = {ex != 8'd0, fx};
        m1   = {e1 != 8'd0, s_coef_one[24:0]};
        ee2  = (xden ? 10'd2 : {1'b0, ex, 1'b0}) + {2'b0, e2};
        ee1  = (xden ? 10'd1 : {2'b0, ex}) + {2'b0, e1} + 10'd127;
        ee0  = {2'b0, e0} + 10'd254;
        mx32 = ee0;
        if (ee1 > mx32) mx32 = ee1;
        if (ee2 > mx32) mx32 = ee2;

        exh   = s_x_bits[14:10];
        fxh   = s_x_bits[9:0];
        e0h   = s_coef_zero[19:15];
        e1h   = s_coef_one[17:13];
        xdenh = (exh == 5'd0) && (fxh != 10'd0);
        mxmh  = {exh != 5'd0, fxh};
        m1h   = {e1h != 5'd0, s_coef_one[12:0]};
        ee1h  = (xdenh ? 6'd1 : {1'b0, exh}) + {1'b0, e1h};
        ee0h  = {1'b0, e0h} + 6'd15;
        mxh   = (ee1h > ee0h) ? ee1h : ee0h;

        sq_next   = 48'(mxm) * 48'(mxm);
        p1_next   = 50'(m1) * 50'(mxm);
        m2_next   = {e2 != 8'd0, s_coef_two[15:0]};
        m0_next   = {e0 != 8'd0, s_coef_zero[29:0]};
        ee0_next  = ee0;
        ee1_next  = ee1;
        ee2_next  = ee2;
        mx_next   = mx32;
        p1h_next  = 25'(m1h) * 25'(mxmh);
        m0h_next  = {e0h != 5'd0, s_coef_zero[14:0]};
        ee0h_next = ee0h;
        ee1h_next = ee1h;
        mxh_next  = mxh;
        if (half_format_reg) begin
            n0_next = s_coef_zero[20];
            n1_next = s_x_bits[15] ^ s_coef_one[18];
        end else begin
            n0_next = s_coef_zero[38];
            n1_next = s_x_bits[31] ^ s_coef_one[33];
        end
        n2_next = s_coef_two[24];
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            sq_reg   <= sq_next;
            p1_reg   <= p1_next;
            m2_reg   <= m2_next;
            m0_reg   <= m0_next;
            ee0_reg  <= ee0_next;
            ee1_reg  <= ee1_next;
            ee2_reg  <= ee2_next;
            mx_reg   <= mx_next;
            p1h_reg  <= p1h_next;
            m0h_reg  <= m0h_next;
            ee0h_reg <= ee0h_next;
            ee1h_reg <= ee1h_next;
            mxh_reg  <= mxh_next;
            n0_reg   <= n0_next;
            n1_reg   <= n1_next;
            n2_reg   <= n2_next;
        end
    end

    // stage 2: c2*xx product, align linear and constant terms
    logic [59:0] t1w, t0w, t1hw, t0hw, t1al, t0al, t1hal, t0hal;
    logic [41:0] t2p_reg, t2p_next;
    logic [9:0]  d2_reg, d2_next, be2_reg, be2_next;
    logic        n2b_reg, n2b_next;
    logic [59:0] t1_reg, t1_next, t0_reg, t0_next;

    always_comb begin
        t1w   = {4'd0, p1_reg[49:19], 25'd0};
        t0w   = {6'd0, m0_reg, 23'd0};
        t1hw  = {34'd0, p1h_reg, 1'b0};
        t0hw  = {35'd0, m0h_reg, 9'd0};
        t1al  = ppfe_pkg::align_term(t1w, mx_reg - ee1_reg, 10'd60, n1_reg);
        t0al  = ppfe_pkg::align_term(t0w, mx_reg - ee0_reg, 10'd60, n0_reg);
        t1hal = ppfe_pkg::align_term(t1hw, {4'd0, mxh_reg - ee1h_reg}, 10'd26, n1_reg);
        t0hal = ppfe_pkg::align_term(t0hw, {4'd0, mxh_reg - ee0h_reg}, 10'd26, n0_reg);
        t2p_next = 42'(m2_reg) * 42'(sq_reg[47:23]);
        d2_next  = mx_reg - ee2_reg;
        n2b_next = n2_reg;
        if (hf_reg[0]) begin
            t1_next  = {32'd0, t1hal[27:0]};
            t0_next  = {32'd0, t0hal[27:0]};
            be2_next = {4'd0, mxh_reg - 6'd13};
        end else begin
            t1_next  = t1al;
            t0_next  = t0al;
            be2_next = mx_reg - 10'd250;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            t2p_reg <= t2p_next;
            d2_reg  <= d2_next;
            n2b_reg <= n2b_next;
            t1_reg  <= t1_next;
            t0_reg  <= t0_next;
            be2_reg <= be2_next;
        end
    end

    // stage 3: align quadratic term
    logic [59:0] t2_reg, t2_next, t1c_reg, t0c_reg;
    logic [9:0]  be3_reg;

    always_comb begin
        if (hf_reg[1]) begin
            t2_next = '0;
        end else begin
            t2_next = ppfe_pkg::align_term({3'd0, t2p_reg, 15'd0}, d2_reg, 10'd60, n2b_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[2]) begin
            t2_reg  <= t2_next;
            t1c_reg <= t1_reg;
            t0c_reg <= t0_reg;
            be3_reg <= be2_reg;
        end
    end

    // stage 4: accumulate
    logic [59:0] sum_reg, sum_next;
    logic [9:0]  be4_reg;

    assign sum_next = t0c_reg + t1c_reg + t2_reg;

    always_ff @(posedge aclk) begin
        if (rdy[3]) begin
            sum_reg <= sum_next;
            be4_reg <= be3_reg;
        end
    end

    // stage 5: sign and magnitude, half results placed at the top of the field
    logic        neg5;
    logic [58:0] mag32;
    logic [26:0] mag16;
    logic [58:0] man_reg, man_next;
    logic        neg_reg, neg_next;
    logic [9:0]  be5_reg;

    always_comb begin
        neg5  = hf_reg[3] ? sum_reg[27] : sum_reg[59];
        mag32 = neg5 ? (59'd0 - sum_reg[58:0]) : sum_reg[58:0];
        mag16 = neg5 ? (27'd0 - sum_reg[26:0]) : sum_reg[26:0];
        man_next = hf_reg[3] ? {mag16, 32'd0} : mag32;
        neg_next = neg5;
    end

    always_ff @(posedge aclk) begin
        if (rdy[4]) begin
            man_reg <= man_next;
            neg_reg <= neg_next;
            be5_reg <= be4_reg;
        end
    end

    // stage 6: leading-zero count
    logic [6:0]  lz_reg, lz_next;
    logic [58:0] man6_reg;
    logic        neg6_reg;
    logic [9:0]  be6_reg;

    always_comb begin
        if (man_reg == '0) begin
            lz_next = hf_reg[4] ? ppfe_pkg::LZ_ZERO_HP : ppfe_pkg::LZ_ZERO_SP;
        end else begin
            lz_next = ppfe_pkg::lead_zeros(man_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[5]) begin
            lz_reg   <= lz_next;
            man6_reg <= man_reg;
            neg6_reg <= neg_reg;
            be6_reg  <= be5_reg;
        end
    end

    // stage 7: normalize or denormalize shift, exponent difference
    logic        den;
    logic [6:0]  amt;
    logic [59:0] base;
    logic [59:0] nm_reg, nm_next;
    logic [7:0]  ne_reg, ne_next;
    logic        den_reg, neg7_reg;

    always_comb begin
        den     = be6_reg <= {3'd0, lz_reg};
        amt     = den ? be6_reg[6:0] : lz_reg;
        base    = den ? {1'b0, man6_reg} : {man6_reg, 1'b0};
        nm_next = base << amt;
        ne_next = be6_reg[7:0] - {1'b0, lz_reg};
    end

    always_ff @(posedge aclk) begin
        if (rdy[6]) begin
            nm_reg   <= nm_next;
            ne_reg   <= ne_next;
            den_reg  <= den;
            neg7_reg <= neg6_reg;
        end
    end

    // stage 8: round and pack into the output register
    logic        lsb, grd, sticky, inc;
    logic [24:0] fr32;
    logic [11:0] fr16;
    logic [7:0]  eo32;
    logic [4:0]  eo16;
    logic [22:0] fo32;
    logic [9:0]  fo16;
    logic [31:0] res_reg, res_next;

    always_comb begin
        if (hf_reg[6]) begin
            lsb    = nm_reg[49];
            grd    = nm_reg[48];
            sticky = nm_reg[47:0] != '0;
        end else begin
            lsb    = nm_reg[36];
            grd    = nm_reg[35];
            sticky = nm_reg[34:0] != '0;
        end
        case (round_mode_reg)
            ppfe_pkg::RND_NEAREST_EVEN: inc = grd && (sticky || lsb);
            ppfe_pkg::RND_DOWN:         inc = neg7_reg && (grd || sticky);
            ppfe_pkg::RND_UP:           inc = !neg7_reg && (grd || sticky);
            ppfe_pkg::RND_NEAREST_AWAY: inc = grd;
            default:                    inc = 1'b0;
        endcase
        fr32 = {1'b0, nm_reg[59:36]} + {24'd0, inc};
        fr16 = {1'b0, nm_reg[59:49]} + {11'd0, inc};

        // single format
        if (den_reg) begin
            fo32 = fr32[22:0];
            eo32 = {7'd0, fr32[23]};
        end else if (fr32[24]) begin
            fo32 = '0;
            eo32 = ne_reg + 8'd1;
        end else begin
            fo32 = fr32[22:0];
            eo32 = ne_reg;
        end

        // half format
        if (den_reg) begin
            fo16 = fr16[9:0];
            eo16 = {4'd0, fr16[10]};
        end else if (fr16[11]) begin
            fo16 = '0;
            eo16 = ne_reg[4:0] + 5'd1;
        end else begin
            fo16 = fr16[9:0];
            eo16 = ne_reg[4:0];
        end

        res_next = hf_reg[6] ? {16'd0, neg7_reg, eo16, fo16} : {neg7_reg, eo32, fo32};
    end

    always_ff @(posedge aclk) begin
        if (rdy[7]) begin
            res_reg <= res_next;
        end
    end

    assign m_result_bits = res_reg;

endmodule

FILE: hdl/ppfe_checker.sv
`include "assert_macros.svh"

module ppfe_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_result_bits
);

    // requests in flight between the two channels
    logic [ppfe_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    always_comb begin
        cnt_next = cnt_reg;
        if (s_valid && s_ready) cnt_next = cnt_next + 1'b1;
        if (m_valid && m_ready) cnt_next = cnt_next - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    `ASSERT_NEXT(a_reset_clears_out, aclk, 1'b1, !aresetn, !m_valid)
    `ASSERT_NEXT(a_out_holds, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_result_bits))
    `ASSERT_SAME(a_no_invented, aclk, aresetn, m_valid, cnt_reg != '0)
    `ASSERT_SAME(a_depth_bound, aclk, aresetn, 1'b1, cnt_reg <= ppfe_pkg::CNT_W'(ppfe_pkg::PIPE_DEPTH))

endmodule

bind piecewise_poly_float_eval_core ppfe_checker u_ppfe_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_result_bits (m_result_bits)
);
